@@ hdl/chd_pkg.sv @@
// Shared types, character codes and the hex digit decoder for the chunked body decoder.
// No dependencies.
package chd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // One raw body byte held in the input register
    typedef struct packed {
        logic       vld;
        logic [7:0] value;
    } byte_req_t;

    // One decoded result
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic       error;
    } res_t;

    // {is_hex, digit value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

@@ hdl/chd_in_stage.sv @@
// Input register of the chunked body decoder: holds one accepted byte.
// Depends on chd_pkg.
module chd_in_stage
    import chd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] in_byte,
    input  logic      take,
    output byte_req_t req
);

    logic       vld_reg;
    logic [7:0] value_reg;
    logic       accept;

    assign in_stall = vld_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (take)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_byte;
        end
    end

    assign req.vld   = vld_reg;
    assign req.value = value_reg;

endmodule

@@ hdl/chd_core.sv @@
// Framing state machine of the chunked body decoder: size, extension, data and CRLF checks.
// Depends on chd_pkg.
module chd_core
    import chd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  byte_req_t req,
    input  logic      ready,
    output logic      step,
    output res_t      res
);

    localparam logic [2:0] PH_SIZE     = 3'd0;
    localparam logic [2:0] PH_SIZE_END = 3'd1;
    localparam logic [2:0] PH_DATA     = 3'd2;
    localparam logic [2:0] PH_DATA_END = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    logic [2:0]           ph_reg, ph_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next, rem_dec;
    logic                 dig_reg, dig_next;
    logic                 cr_reg, cr_next;
    logic                 ext_reg, ext_next;

    logic [7:0] b;
    logic [4:0] hex;
    logic       se_run, se_cr, se_ext;

    assign step    = req.vld && ready;
    assign b       = req.value;
    assign hex     = hex_decode(b);
    assign rem_dec = rem_reg - 1'b1;

    always_comb
    begin
        ph_next  = ph_reg;
        rem_next = rem_reg;
        dig_next = dig_reg;
        cr_next  = cr_reg;
        ext_next = ext_reg;
        se_run   = 1'b0;
        se_cr    = cr_reg;
        se_ext   = ext_reg;
        res.data_valid = 1'b0;
        res.data_byte  = 8'h00;

        unique case (ph_reg)
            PH_SIZE:
            begin
                if (hex[4])
                begin
                    if (rem_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        ph_next = PH_ERROR;
                    end
                    else
                    begin
                        rem_next = {rem_reg[SIZE_BITS-5:0], hex[3:0]};
                        dig_next = 1'b1;
                    end
                end
                else if (!dig_reg)
                begin
                    ph_next = PH_ERROR;
                end
                else if (rem_reg == '0)
                begin
                    ph_next = PH_DONE;
                end
                else
                begin
                    // the terminating byte is handled as the first size-end byte
                    se_run = 1'b1;
                    se_cr  = 1'b0;
                    se_ext = 1'b0;
                end
            end
            PH_SIZE_END:
            begin
                se_run = 1'b1;
            end
            PH_DATA:
            begin
                res.data_valid = 1'b1;
                res.data_byte  = b;
                rem_next       = rem_dec;
                if (rem_dec == '0)
                begin
                    ph_next = PH_DATA_END;
                    cr_next = 1'b0;
                end
            end
            PH_DATA_END:
            begin
                if (b == CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else if (b == CH_LF && cr_reg)
                begin
                    cr_next  = 1'b0;
                    dig_next = 1'b0;
                    rem_next = '0;
                    ph_next  = PH_SIZE;
                end
                else
                begin
                    ph_next = PH_ERROR;
                end
            end
            PH_DONE:
            begin
                ph_next = PH_DONE;
            end
            default:
            begin
                ph_next = PH_ERROR;
            end
        endcase

        if (se_run)
        begin
            ph_next  = PH_SIZE_END;
            cr_next  = se_cr;
            ext_next = se_ext;
            if (se_ext)
            begin
                // extension text is skipped; CR closes it and starts the CRLF
                if (b == CH_CR)
                begin
                    ext_next = 1'b0;
                    cr_next  = 1'b1;
                end
            end
            else if (b == CH_SEMI)
            begin
                ext_next = 1'b1;
            end
            else if (b == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else if (b == CH_LF && se_cr)
            begin
                cr_next = 1'b0;
                ph_next = PH_DATA;
            end
            else
            begin
                ph_next = PH_ERROR;
            end
        end

        res.done_res = (ph_next == PH_DONE);
        res.error    = (ph_next == PH_ERROR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_SIZE;
            rem_reg <= '0;
            dig_reg <= 1'b0;
            cr_reg  <= 1'b0;
            ext_reg <= 1'b0;
        end
        else if (step)
        begin
            ph_reg  <= ph_next;
            rem_reg <= rem_next;
            dig_reg <= dig_next;
            cr_reg  <= cr_next;
            ext_reg <= ext_next;
        end
    end

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_DONE |=> ph_reg == PH_DONE)
        else $error("done phase left");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_ERROR |=> ph_reg == PH_ERROR)
        else $error("error phase left");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_DATA |-> rem_reg != '0)
        else $error("data phase with zero bytes left");

    a_ext_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ext_reg |-> ph_reg == PH_SIZE_END)
        else $error("extension flag outside size end");

endmodule

@@ hdl/chd_out_stage.sv @@
// Result register of the chunked body decoder, with its valid/stall handshake.
// Depends on chd_pkg.
module chd_out_stage
    import chd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_valid,
    output logic [7:0] data_byte,
    output logic       done_res,
    output logic       error
);

    logic out_valid_reg;
    res_t res_reg;

    assign ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = res_reg.data_valid;
    assign data_byte  = res_reg.data_byte;
    assign done_res   = res_reg.done_res;
    assign error      = res_reg.error;

endmodule

@@ hdl/http_chunked_body_decoder_top.sv @@
// HTTP chunked body decoder, one body byte per request, one result per request.
// Path: each accepted byte is held in the input register, then its result in the result
// register; throughput is one byte per cycle while out_stall is low. Reset clears the
// valid flags of both register stages and returns the framing state to the start of a
// chunk size with no digits, zero count and no flags.
// Depends on chd_pkg, chd_in_stage, chd_core, chd_out_stage.
module http_chunked_body_decoder_top
    import chd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       data_valid,
    output logic [7:0] data_byte,
    output logic       done_res,
    output logic       error
);

    byte_req_t req;
    res_t      res;
    logic      ready;
    logic      step;

    chd_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .take     (ready),
        .req      (req)
    );

    chd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ready (ready),
        .step  (step),
        .res   (res)
    );

    chd_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .res        (res),
        .ready      (ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .done_res   (done_res),
        .error      (error)
    );

endmodule
